@@ rtl/core/nll_pkg.sv @@
// ----------------------------------------------------------------------------
// nll_pkg
// Shared types, character codes and scanner helpers for the numeric literal
// length recognizer.
// ----------------------------------------------------------------------------
package nll_pkg;

  // Width of the internal character counters.
  localparam int LEN_W = 16;
  localparam int OUT_LEN_W = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W = 1;
  // Wide enough to compare counters against the offset and the output maximum.
  localparam int CMP_W = LEN_W + OUT_LEN_W;

  localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_NUMBER_KIND = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_OFFSET = 1'd1;

  // Number kinds. The unused code behaves as unsigned integer.
  localparam logic [1:0] KIND_FLOAT = 2'd0;
  localparam logic [1:0] KIND_SINT = 2'd1;
  localparam logic [1:0] KIND_UINT = 2'd2;

  // Character codes.
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_DOT = 8'h2E;
  localparam logic [7:0] CH_EXP_LO = 8'h65;
  localparam logic [7:0] CH_EXP_UP = 8'h45;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS = 8'h2B;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;

  typedef enum logic [3:0] {
    ST_LEAD,
    ST_SIGN,
    ST_INT,
    ST_DOT0,
    ST_FRAC,
    ST_EXP,
    ST_EXPS,
    ST_EXPD,
    ST_TRAIL,
    ST_DEAD
  } scan_state_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } in_item_t;

  typedef struct packed {
    logic [OUT_LEN_W-1:0] match_length;
    logic                 whole_numeric;
  } out_item_t;

  // Result of one scanner step.
  typedef struct packed {
    scan_state_t state;
    logic        accepting;
  } dfa_step_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB);
  endfunction

  function automatic logic is_exp(input logic [7:0] c);
    return (c == CH_EXP_LO) || (c == CH_EXP_UP);
  endfunction

  function automatic logic is_sign(input logic [7:0] c);
    return (c == CH_PLUS) || (c == CH_MINUS);
  endfunction

endpackage

@@ rtl/core/nll_dfa.sv @@
// ----------------------------------------------------------------------------
// nll_dfa
// One step of the number scanner: next state from the current state, the
// character and the number kind, plus whether the new state accepts.
// ----------------------------------------------------------------------------
module nll_dfa (
  input  nll_pkg::scan_state_t state,
  input  logic [7:0]           char_code,
  input  logic [1:0]           number_kind,
  output nll_pkg::dfa_step_t   step
);
  import nll_pkg::*;

  logic        flt;
  logic        sign_ok;
  logic        dig;
  logic        blank;
  logic        expc;
  logic        sgn;
  logic        dot;
  scan_state_t nxt;

  assign flt   = (number_kind == KIND_FLOAT);
  assign dig   = is_digit(char_code);
  assign blank = is_blank(char_code);
  assign expc  = is_exp(char_code);
  assign sgn   = is_sign(char_code);
  assign dot   = (char_code == CH_DOT);
  // Unsigned integers allow only a plus sign.
  assign sign_ok = (flt || (number_kind == KIND_SINT)) ? sgn : (char_code == CH_PLUS);

  always_comb begin
    unique case (state)
      ST_LEAD, ST_SIGN: begin
        if ((state == ST_LEAD) && blank) nxt = ST_LEAD;
        else if ((state == ST_LEAD) && sign_ok) nxt = ST_SIGN;
        else if (dig) nxt = ST_INT;
        else if (flt && dot) nxt = ST_DOT0;
        else nxt = ST_DEAD;
      end
      ST_INT: begin
        if (dig) nxt = ST_INT;
        else if (flt && dot) nxt = ST_FRAC;
        else if (flt && expc) nxt = ST_EXP;
        else if (blank) nxt = ST_TRAIL;
        else nxt = ST_DEAD;
      end
      ST_DOT0: nxt = dig ? ST_FRAC : ST_DEAD;
      ST_FRAC: begin
        if (dig) nxt = ST_FRAC;
        else if (expc) nxt = ST_EXP;
        else if (blank) nxt = ST_TRAIL;
        else nxt = ST_DEAD;
      end
      ST_EXP: begin
        if (dig) nxt = ST_EXPD;
        else if (sgn) nxt = ST_EXPS;
        else nxt = ST_DEAD;
      end
      ST_EXPS: nxt = dig ? ST_EXPD : ST_DEAD;
      ST_EXPD: begin
        if (dig) nxt = ST_EXPD;
        else if (blank) nxt = ST_TRAIL;
        else nxt = ST_DEAD;
      end
      ST_TRAIL: nxt = blank ? ST_TRAIL : ST_DEAD;
      default:  nxt = ST_DEAD;
    endcase
  end

  assign step.state = nxt;
  assign step.accepting = (nxt == ST_INT) || (nxt == ST_FRAC) ||
                          (nxt == ST_EXPD) || (nxt == ST_TRAIL);

endmodule

@@ rtl/core/nll_out.sv @@
// ----------------------------------------------------------------------------
// nll_out
// Result register: holds one finished result until the consumer takes it.
// ----------------------------------------------------------------------------
module nll_out (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  nll_pkg::out_item_t load_data,
  output logic               out_valid,
  input  logic               out_ready,
  output nll_pkg::out_item_t out_data,
  output logic               room
);
  import nll_pkg::*;

  logic      valid_r;
  logic      valid_nxt;
  out_item_t data_r;

  // A new result may enter when the register is empty or drains this cycle.
  assign room = !valid_r || out_ready;
  assign valid_nxt = load ? 1'b1 : (valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (load) begin
      data_r <= load_data;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

@@ rtl/core/numeric_literal_length.sv @@
// ----------------------------------------------------------------------------
// numeric_literal_length
// Finds the longest numeric prefix of a character string fed one byte per beat.
// ----------------------------------------------------------------------------
// The result of a string appears on out_valid in the cycle after its last beat
// is accepted.
// Throughput: one character beat per cycle while the result register has room;
// the scanner step lies between the string-state and the result registers.
// Reset (synchronous, rst_n low): number_kind and start_offset return to zero,
// the scanner returns to the leading blank state and the result register empties.
module numeric_literal_length (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  nll_pkg::in_item_t                  in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output nll_pkg::out_item_t                 out_data,
  input  logic                               cfg_we,
  input  logic [nll_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [nll_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import nll_pkg::*;

  // Configuration registers.
  logic [1:0]            number_kind_r;
  logic [CFG_DATA_W-1:0] start_offset_r;

  // Per-string state.
  scan_state_t           state_r;
  scan_state_t           state_nxt;
  logic                  started_r;
  logic                  started_nxt;
  logic [LEN_W-1:0]      seen_r;
  logic [LEN_W-1:0]      seen_nxt;
  logic [LEN_W-1:0]      acc_len_r;
  logic [LEN_W-1:0]      acc_len_nxt;

  logic                  accept_in;
  logic                  begin_now;
  logic [LEN_W-1:0]      count_base;
  logic [LEN_W-1:0]      count_inc;
  logic [CMP_W-1:0]      acc_ext;
  logic                  room;
  logic                  load;
  dfa_step_t             step;
  out_item_t             result;

  assign accept_in = in_valid && in_ready;
  assign in_ready  = room;

  // Recognition starts once start_offset characters have gone by. The counter
  // restarts at zero for the first recognized character.
  assign begin_now  = !started_r && (CMP_W'(seen_r) >= CMP_W'(start_offset_r));
  assign started_nxt = started_r || begin_now;
  assign count_base = begin_now ? '0 : seen_r;
  assign count_inc  = (count_base == LEN_MAX) ? LEN_MAX : count_base + 1'b1;

  nll_dfa u_dfa (
    .state       (state_r),
    .char_code   (in_data.char_code),
    .number_kind (number_kind_r),
    .step        (step)
  );

  // While still skipping, the scanner stays put and only the counter moves.
  always_comb begin
    seen_nxt    = count_inc;
    state_nxt   = state_r;
    acc_len_nxt = acc_len_r;
    if (started_nxt) begin
      state_nxt = step.state;
      if (step.accepting) begin
        acc_len_nxt = count_inc;
      end
    end
  end

  // The reported length saturates at the output field's maximum.
  assign acc_ext = CMP_W'(acc_len_nxt);
  assign result.match_length  = (acc_ext > CMP_W'({OUT_LEN_W{1'b1}})) ?
                                {OUT_LEN_W{1'b1}} : acc_ext[OUT_LEN_W-1:0];
  assign result.whole_numeric = started_nxt && step.accepting;

  assign load = accept_in && in_data.last_char;

  nll_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .load_data (result),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .room      (room)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      number_kind_r  <= KIND_FLOAT;
      start_offset_r <= '0;
      state_r        <= ST_LEAD;
      started_r      <= 1'b0;
      seen_r         <= '0;
      acc_len_r      <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_NUMBER_KIND:  number_kind_r  <= cfg_wdata[1:0];
          CFG_START_OFFSET: start_offset_r <= cfg_wdata;
          default: ;
        endcase
      end
      // The last character of a string clears the string state for the next.
      if (accept_in) begin
        if (in_data.last_char) begin
          state_r   <= ST_LEAD;
          started_r <= 1'b0;
          seen_r    <= '0;
          acc_len_r <= '0;
        end else begin
          state_r   <= state_nxt;
          started_r <= started_nxt;
          seen_r    <= seen_nxt;
          acc_len_r <= acc_len_nxt;
        end
      end
    end
  end

endmodule

@@ test/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the numeric literal length recognizer. Strings are
// fed one character beat at a time while a scanner model, kept in step with
// every accepted beat, predicts the match length and the whole-string flag of
// each result beat. The run uses directed cases, random strings under several
// idle patterns and a long output stall.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import nll_pkg::*;

  localparam int CLK_HALF = 5;
  localparam int CYCLE_LIMIT = 1_000_000;
  // The spare kind code has no name in the package; it behaves as unsigned.
  localparam logic [1:0] KIND_SPARE = 2'd3;

  // Signals toward and from the block. All inputs start at known values.
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Scanner model state: configuration plus the per-string scan state.
  logic [1:0] kind_reg;
  logic [CFG_DATA_W-1:0] offset_reg;
  scan_state_t scan_st;
  logic [LEN_W-1:0] seen_cnt;
  logic [LEN_W-1:0] accept_len;
  logic started;

  // Results predicted but not yet seen on the output channel, oldest first.
  out_item_t expected_results[$];
  // Characters of the string that is about to be sent.
  logic [7:0] str_buf[$];

  int errors = 0;
  int cycle_count = 0;
  int src_idle_pct = 0;
  int sink_idle_pct = 0;
  int hold_left = 0;

  numeric_literal_length DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #CLK_HALF clk = ~clk;

  // The watchdog ends a run that hangs, for instance on a lost ready.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Scanner model
  // ---------------------------------------------------------------------------

  function automatic logic digit_ch(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic blank_ch(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB);
  endfunction

  // A string ends in an accepted number only in these four states.
  function automatic logic accepting(input scan_state_t s);
    return (s == ST_INT) || (s == ST_FRAC) || (s == ST_EXPD) || (s == ST_TRAIL);
  endfunction

  // One transition of the recognizer for the current number kind.
  function automatic scan_state_t scan_next(input scan_state_t s, input logic [7:0] c);
    logic dig, blk, ex, sgn, flt, sign_ok;
    scan_state_t nxt;
    dig = digit_ch(c);
    blk = blank_ch(c);
    ex = (c == CH_EXP_LO) || (c == CH_EXP_UP);
    sgn = (c == CH_PLUS) || (c == CH_MINUS);
    flt = (kind_reg == KIND_FLOAT);
    // Unsigned and the spare kind take a plus sign only.
    sign_ok = (flt || kind_reg == KIND_SINT) ? sgn : (c == CH_PLUS);
    nxt = ST_DEAD;
    case (s)
      ST_LEAD, ST_SIGN: begin
        // Leading blanks and the sign are only legal before the first digit.
        if (s == ST_LEAD && blk) nxt = ST_LEAD;
        else if (s == ST_LEAD && sign_ok) nxt = ST_SIGN;
        else if (dig) nxt = ST_INT;
        else if (flt && c == CH_DOT) nxt = ST_DOT0;
      end
      ST_INT: begin
        if (dig) nxt = ST_INT;
        else if (flt && c == CH_DOT) nxt = ST_FRAC;
        else if (flt && ex) nxt = ST_EXP;
        else if (blk) nxt = ST_TRAIL;
      end
      ST_DOT0: if (dig) nxt = ST_FRAC;
      ST_FRAC: begin
        if (dig) nxt = ST_FRAC;
        else if (ex) nxt = ST_EXP;
        else if (blk) nxt = ST_TRAIL;
      end
      ST_EXP: begin
        if (dig) nxt = ST_EXPD;
        else if (sgn) nxt = ST_EXPS;
      end
      ST_EXPS: if (dig) nxt = ST_EXPD;
      ST_EXPD: begin
        if (dig) nxt = ST_EXPD;
        else if (blk) nxt = ST_TRAIL;
      end
      ST_TRAIL: if (blk) nxt = ST_TRAIL;
      default: nxt = ST_DEAD;
    endcase
    return nxt;
  endfunction

  task automatic clear_scan();
    scan_st = ST_LEAD;
    seen_cnt = '0;
    accept_len = '0;
    started = 1'b0;
  endtask

  // Advances the model by one accepted character beat and queues the result
  // that a final character produces.
  task automatic scanner_step(input in_item_t beat);
    out_item_t res;
    // The skip counter is reused as the length counter once the offset is met.
    if (!started && seen_cnt >= offset_reg) begin
      started = 1'b1;
      seen_cnt = '0;
    end
    if (started) scan_st = scan_next(scan_st, beat.char_code);
    if (seen_cnt != LEN_MAX) seen_cnt = seen_cnt + 1'b1;
    if (started && accepting(scan_st)) accept_len = seen_cnt;
    if (beat.last_char) begin
      res.match_length = accept_len;
      res.whole_numeric = started && accepting(scan_st);
      expected_results.push_back(res);
      clear_scan();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Output side: ready pattern and result check
  // ---------------------------------------------------------------------------

  // The receiver holds ready low while hold_left runs down, and otherwise
  // drops ready at random with the current idle percentage.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready = 1'b0;
      hold_left--;
    end else begin
      out_ready = ($urandom_range(99) >= sink_idle_pct);
    end
  end

  task report_mismatch(input string what, input int got, input int want);
    $display("mismatch at cycle %0d: %s, got %0d, expected %0d",
             cycle_count, what, got, want);
    errors++;
  endtask

  // Each accepted result beat is compared with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result beat with nothing pending",
                        int'(out_data.match_length), -1);
      end else begin
        if (out_data.match_length !== expected_results[0].match_length)
          report_mismatch("match_length", int'(out_data.match_length),
                          int'(expected_results[0].match_length));
        if (out_data.whole_numeric !== expected_results[0].whole_numeric)
          report_mismatch("whole_numeric", int'(out_data.whole_numeric),
                          int'(expected_results[0].whole_numeric));
        void'(expected_results.pop_front());
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input side and configuration
  // ---------------------------------------------------------------------------

  // Sends one character beat. It is entered and left just after a falling edge,
  // so every input changes half a period away from the sampling edge.
  task automatic send_char(input logic [7:0] c, input logic last);
    in_item_t beat;
    beat.char_code = c;
    beat.last_char = last;
    while ($urandom_range(99) < src_idle_pct) @(negedge clk);
    in_data = beat;
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    scanner_step(beat);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // Sends the buffered string, marking its final character.
  task automatic send_buffer();
    for (int i = 0; i < str_buf.size(); i++)
      send_char(str_buf[i], i == str_buf.size() - 1);
  endtask

  task automatic send_text(input string s);
    str_buf.delete();
    for (int i = 0; i < s.len(); i++) str_buf.push_back(s[i]);
    send_buffer();
  endtask

  // Waits until every predicted result has come out, plus a margin that
  // covers the result register, and leaves at a falling edge.
  task automatic wait_idle();
    while (expected_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    if (idx == CFG_NUMBER_KIND) kind_reg = val[1:0];
    else offset_reg = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Registers change only while the block holds no string and no result.
  // The kind write carries random upper bits, which the block must ignore.
  task automatic set_config(input logic [1:0] kind, input logic [CFG_DATA_W-1:0] offset);
    logic [CFG_DATA_W-1:0] kind_word;
    wait_idle();
    kind_word = CFG_DATA_W'($urandom);
    kind_word[1:0] = kind;
    write_reg(CFG_NUMBER_KIND, kind_word);
    write_reg(CFG_START_OFFSET, offset);
  endtask

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [7:0] rand_digit();
    return CH_ZERO + 8'($urandom_range(9));
  endfunction

  function automatic logic [7:0] rand_blank();
    return $urandom_range(1) ? CH_SPACE : CH_TAB;
  endfunction

  function automatic logic [7:0] rand_sign();
    return $urandom_range(1) ? CH_PLUS : CH_MINUS;
  endfunction

  // Builds one random string. Most are number-shaped with random parts so the
  // scanner reaches the fraction, exponent and trailing states; the rest are
  // raw bytes or shuffles of the characters that matter to the scanner.
  task automatic make_literal();
    string alphabet;
    int pick;
    alphabet = "0123456789+-.eE \t";
    str_buf.delete();
    // Characters in the skipped window are arbitrary.
    if (offset_reg <= 4) repeat (offset_reg) str_buf.push_back(rand_byte());
    pick = $urandom_range(99);
    if (pick < 70) begin
      repeat ($urandom_range(2)) str_buf.push_back(rand_blank());
      if ($urandom_range(1)) str_buf.push_back(rand_sign());
      repeat ($urandom_range(4)) str_buf.push_back(rand_digit());
      if ($urandom_range(1)) begin
        str_buf.push_back(CH_DOT);
        repeat ($urandom_range(3)) str_buf.push_back(rand_digit());
      end
      if ($urandom_range(99) < 35) begin
        str_buf.push_back($urandom_range(1) ? CH_EXP_LO : CH_EXP_UP);
        if ($urandom_range(1)) str_buf.push_back(rand_sign());
        // No exponent digits leaves an incomplete tail.
        repeat ($urandom_range(2)) str_buf.push_back(rand_digit());
      end
      repeat ($urandom_range(2)) str_buf.push_back(rand_blank());
      if ($urandom_range(99) < 25) repeat ($urandom_range(1, 3)) str_buf.push_back(rand_byte());
    end else if (pick < 85) begin
      repeat ($urandom_range(1, 6)) str_buf.push_back(rand_byte());
    end else begin
      repeat ($urandom_range(1, 8))
        str_buf.push_back(alphabet[$urandom_range(alphabet.len() - 1)]);
    end
    if (str_buf.size() == 0) str_buf.push_back(rand_digit());
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Short strings for each kind and each named corner of the scanner.
  task automatic test_directed();
    src_idle_pct = 20;
    sink_idle_pct = 20;
    set_config(KIND_FLOAT, 16'd0);
    send_text(" -1.5e+2 ");   // every float part, then a trailing blank
    send_text("1.");          // a bare trailing dot still counts
    send_text("2e");          // an exponent marker without digits is dropped
    send_text(" +");          // blanks and a sign alone are no number
    str_buf.delete();
    str_buf.push_back(8'h00);
    send_buffer();
    str_buf.delete();
    str_buf.push_back(CH_NINE);
    str_buf.push_back(8'hFF);
    send_buffer();
    set_config(KIND_SINT, 16'd0);
    send_text("-3.");         // no fraction in integer modes
    set_config(KIND_UINT, 16'd0);
    send_text("-4");          // a minus sign kills an unsigned number
    set_config(KIND_SPARE, 16'd0);
    send_text("+6\t");        // the spare kind acts as unsigned
    set_config(KIND_FLOAT, 16'd2);
    send_text("ab0");         // the first two characters are skipped
    set_config(KIND_FLOAT, 16'd5);
    send_text("12");          // the offset lies past the end of the string
  endtask

  // The receiver stalls for a long stretch while strings keep coming, so the
  // result register fills and the input side must stall too.
  task automatic test_backpressure();
    set_config(KIND_FLOAT, 16'd0);
    src_idle_pct = 0;
    sink_idle_pct = 0;
    @(posedge clk);
    hold_left = 300;
    @(negedge clk);
    send_text("1234");
    send_text("+5");
    send_text(" 6.0 ");
    send_text("x7");
    send_text(".25e9");
    send_text("8");
  endtask

  task automatic test_random(input int src_pct, input int sink_pct, input int item_goal);
    int sent;
    int strings_left;
    int pick;
    logic [CFG_DATA_W-1:0] offset;
    src_idle_pct = src_pct;
    sink_idle_pct = sink_pct;
    sent = 0;
    strings_left = 0;
    while (sent < item_goal) begin
      if (strings_left == 0) begin
        // Mostly no offset or a small one, sometimes one past any string here.
        pick = $urandom_range(99);
        if (pick < 55) offset = 16'd0;
        else if (pick < 85) offset = CFG_DATA_W'($urandom_range(1, 4));
        else if (pick < 93) offset = CFG_DATA_W'($urandom_range(5, 40));
        else offset = 16'hFFFF;
        set_config(2'($urandom_range(3)), offset);
        strings_left = $urandom_range(8, 30);
      end
      make_literal();
      sent += str_buf.size();
      send_buffer();
      strings_left--;
    end
  endtask

  initial begin
    // Synchronous reset held low from time zero, released off the edge.
    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    kind_reg = KIND_FLOAT;
    offset_reg = '0;
    clear_scan();

    test_directed();
    test_backpressure();
    test_random(33, 64, 450);
    test_random(64, 33, 450);
    test_random(0, 0, 400);

    // Drain the last result and let the block run on before the verdict.
    in_valid = 1'b0;
    wait_idle();
    repeat (4) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ numeric_literal_length.f @@
rtl/core/nll_pkg.sv
rtl/core/nll_dfa.sv
rtl/core/nll_out.sv
rtl/core/numeric_literal_length.sv
test/testbench.sv
